// File: hw/rtl/tnn4d_pkg.sv
// Shared types and constants for the three-nearest-neighbours 4D search block.
// No dependencies.
`default_nettype none

package tnn4d_pkg;

   localparam int MAX_POINTS_DEF = 512;
   localparam int COORD_W        = 16;
   localparam int POINT_W        = 4 * COORD_W;
   localparam int INDEX_W        = 9;
   localparam int COUNT_W        = 2;
   localparam int PIU_W          = 10;
   localparam int DIFF_W         = COORD_W + 1;
   localparam int SQ_W           = 2 * COORD_W;
   localparam int PAIR_W         = SQ_W + 1;
   localparam int DIST_W         = SQ_W + 2;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // register select bit of the csr byte address
   localparam logic REG_POINTS_IN_USE = 1'b0;

   localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIST_W-1:0]  dist_type;

endpackage

`default_nettype wire

// File: hw/rtl/tnn4d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tnn4d_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/three_nearest_neighbours_4d.sv
// Three nearest neighbours of a stored 4D point: point memory, distance pipe, top-3 keeper.
// Depends on tnn4d_pkg and tnn4d_ram.
// Load: no result. Query out of range: result in the cycle after start.
// Query in range: FETCH and HOLD read the queried point, SCAN reads the n points in use, DRAIN
// waits for the pipe to empty before rsp_strobe, n = points in use; one point RAM read per scan cycle.
// The next request may start in the cycle that carries the result.
// Synchronous reset clears control and points_in_use; point memory is not cleared.
`default_nettype none

module three_nearest_neighbours_4d #(
   parameter int MAX_POINTS = tnn4d_pkg::MAX_POINTS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_action,
   input  wire logic [tnn4d_pkg::INDEX_W-1:0]      req_point_index,
   input  wire logic [tnn4d_pkg::COORD_W-1:0]      req_coord_x,
   input  wire logic [tnn4d_pkg::COORD_W-1:0]      req_coord_y,
   input  wire logic [tnn4d_pkg::COORD_W-1:0]      req_coord_z,
   input  wire logic [tnn4d_pkg::COORD_W-1:0]      req_coord_w,
   output logic                                    rsp_strobe,
   output logic      [tnn4d_pkg::INDEX_W-1:0]      rsp_first_index,
   output logic      [tnn4d_pkg::INDEX_W-1:0]      rsp_second_index,
   output logic      [tnn4d_pkg::INDEX_W-1:0]      rsp_third_index,
   output logic      [tnn4d_pkg::COUNT_W-1:0]      rsp_found_count,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tnn4d_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [tnn4d_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [tnn4d_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                    pready
);

   import tnn4d_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_HOLD  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [PIU_W-1:0]   piu_ff, piu_in;
   logic [IDX_W-1:0]   qidx_ff, qidx_in;
   logic [POINT_W-1:0] qpt_ff, qpt_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;

   // pipeline: read data, diffs, squares, pair sums, total
   logic               rdv_ff, rdv_in;
   logic [IDX_W-1:0]   rdi_ff, rdi_in;
   logic               s1v_ff, s1v_in;
   logic [IDX_W-1:0]   s1i_ff;
   logic signed [DIFF_W-1:0] s1d_ff [4];
   logic               s2v_ff, s2v_in;
   logic [IDX_W-1:0]   s2i_ff;
   logic [SQ_W-1:0]    s2q_ff [4];
   logic               s3v_ff, s3v_in;
   logic [IDX_W-1:0]   s3i_ff;
   logic [PAIR_W-1:0]  s3p_ff [2];
   logic               s4v_ff, s4v_in;
   logic [IDX_W-1:0]   s4i_ff;
   dist_type           s4d_ff;

   // top-3 keeper
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   dist_type           bd_ff [3];
   dist_type           bd_in [3];
   logic [IDX_W-1:0]   bi_ff [3];
   logic [IDX_W-1:0]   bi_in [3];

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_W-1:0] rsp_i0_ff, rsp_i0_in;
   logic [INDEX_W-1:0] rsp_i1_ff, rsp_i1_in;
   logic [INDEX_W-1:0] rsp_i2_ff, rsp_i2_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic               accept;
   logic               csr_write;
   logic [CMP_W-1:0]   n_cmp;
   logic [CMP_W-1:0]   req_idx_cmp;
   logic [IDX_W-1:0]   last_idx;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [POINT_W-1:0] rd_data;
   logic               pipe_busy;
   logic               lt0, lt1, lt2;

   assign accept      = start && !busy;
   assign csr_write   = psel && penable && pwrite && pready;
   assign pready      = 1'b1;
   assign prdata      = (paddr[2] == REG_POINTS_IN_USE) ? CSR_DATA_W'(piu_ff) : '0;
   assign n_cmp       = (CMP_W'(piu_ff) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
                                                              : CMP_W'(piu_ff);
   assign req_idx_cmp = CMP_W'(req_point_index);
   assign last_idx    = IDX_W'(n_cmp - CMP_W'(1));
   assign wr_en       = accept && (req_action == ACT_LOAD) &&
                        (req_idx_cmp < CMP_W'(MAX_POINTS));
   assign rd_addr     = (state_ff == ST_FETCH) ? qidx_ff : scan_ff;
   assign pipe_busy   = rdv_ff || s1v_ff || s2v_ff || s3v_ff || s4v_ff;
   assign busy        = (state_ff != ST_IDLE);

   tnn4d_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_point_index)),
      .wr_data ({req_coord_w, req_coord_z, req_coord_y, req_coord_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign s1v_in = rdv_ff && (rdi_ff != qidx_ff);
   assign s2v_in = s1v_ff;
   assign s3v_in = s2v_ff;
   assign s4v_in = s3v_ff;

   assign lt0 = (cnt_ff < 2'd1) || (s4d_ff < bd_ff[0]);
   assign lt1 = (cnt_ff < 2'd2) || (s4d_ff < bd_ff[1]);
   assign lt2 = (cnt_ff < 2'd3) || (s4d_ff < bd_ff[2]);

   always_comb begin
      state_in      = state_ff;
      piu_in        = piu_ff;
      qidx_in       = qidx_ff;
      qpt_in        = qpt_ff;
      scan_in       = scan_ff;
      rdv_in        = 1'b0;
      rdi_in        = scan_ff;
      cnt_in        = cnt_ff;
      bd_in         = bd_ff;
      bi_in         = bi_ff;
      rsp_strobe_in = 1'b0;
      rsp_i0_in     = rsp_i0_ff;
      rsp_i1_in     = rsp_i1_ff;
      rsp_i2_in     = rsp_i2_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      if (csr_write && (paddr[2] == REG_POINTS_IN_USE)) begin
         piu_in = pwdata[PIU_W-1:0];
      end

      // insertion, ascending scan order keeps the lowest index on ties
      if (s4v_ff && (lt0 || lt1 || lt2)) begin
         priority if (lt0) begin
            bd_in[2] = bd_ff[1];  bi_in[2] = bi_ff[1];
            bd_in[1] = bd_ff[0];  bi_in[1] = bi_ff[0];
            bd_in[0] = s4d_ff;    bi_in[0] = s4i_ff;
         end else if (lt1) begin
            bd_in[2] = bd_ff[1];  bi_in[2] = bi_ff[1];
            bd_in[1] = s4d_ff;    bi_in[1] = s4i_ff;
         end else begin
            bd_in[2] = s4d_ff;    bi_in[2] = s4i_ff;
         end
         if (cnt_ff != COUNT_FULL) begin
            cnt_in = cnt_ff + 2'd1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_QUERY)) begin
               if (req_idx_cmp < n_cmp) begin
                  qidx_in  = IDX_W'(req_point_index);
                  cnt_in   = '0;
                  bi_in    = '{default: '0};
                  state_in = ST_FETCH;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_i0_in     = '0;
                  rsp_i1_in     = '0;
                  rsp_i2_in     = '0;
                  rsp_cnt_in    = '0;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            qpt_in   = rd_data;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rdv_in = 1'b1;
            if (scan_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               rsp_strobe_in = 1'b1;
               rsp_i0_in     = INDEX_W'(bi_ff[0]);
               rsp_i1_in     = INDEX_W'(bi_ff[1]);
               rsp_i2_in     = INDEX_W'(bi_ff[2]);
               rsp_cnt_in    = cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         piu_ff        <= '0;
         rdv_ff        <= 1'b0;
         s1v_ff        <= 1'b0;
         s2v_ff        <= 1'b0;
         s3v_ff        <= 1'b0;
         s4v_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         piu_ff        <= piu_in;
         rdv_ff        <= rdv_in;
         s1v_ff        <= s1v_in;
         s2v_ff        <= s2v_in;
         s3v_ff        <= s3v_in;
         s4v_ff        <= s4v_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      qidx_ff    <= qidx_in;
      qpt_ff     <= qpt_in;
      scan_ff    <= scan_in;
      rdi_ff     <= rdi_in;
      bd_ff      <= bd_in;
      bi_ff      <= bi_in;
      rsp_i0_ff  <= rsp_i0_in;
      rsp_i1_ff  <= rsp_i1_in;
      rsp_i2_ff  <= rsp_i2_in;
      rsp_cnt_ff <= rsp_cnt_in;
      s1i_ff     <= rdi_ff;
      s2i_ff     <= s1i_ff;
      s3i_ff     <= s2i_ff;
      s4i_ff     <= s3i_ff;
      for (int c = 0; c < 4; c++) begin
         s1d_ff[c] <= $signed({rd_data[c*COORD_W+COORD_W-1], rd_data[c*COORD_W +: COORD_W]})
                    - $signed({qpt_ff[c*COORD_W+COORD_W-1], qpt_ff[c*COORD_W +: COORD_W]});
         s2q_ff[c] <= SQ_W'(s1d_ff[c] * s1d_ff[c]);
      end
      s3p_ff[0] <= PAIR_W'(s2q_ff[0]) + PAIR_W'(s2q_ff[1]);
      s3p_ff[1] <= PAIR_W'(s2q_ff[2]) + PAIR_W'(s2q_ff[3]);
      s4d_ff    <= DIST_W'(s3p_ff[0]) + DIST_W'(s3p_ff[1]);
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_first_index  = rsp_i0_ff;
   assign rsp_second_index = rsp_i1_ff;
   assign rsp_third_index  = rsp_i2_ff;
   assign rsp_found_count  = rsp_cnt_ff;

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("point RAM written during a query");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CMP_W'(scan_ff) < n_cmp))
      else $error("scan index past points in use");

   a_rank_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_found_count >= 2'd2)) |-> (rsp_first_index != rsp_second_index))
      else $error("same point at two ranks");

   a_rank_distinct3: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_found_count == COUNT_FULL)) |->
         ((rsp_third_index != rsp_first_index) && (rsp_third_index != rsp_second_index)))
      else $error("third rank repeats a point");

   a_query_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_QUERY) && (req_idx_cmp < n_cmp)) |=>
         (state_ff == ST_FETCH) && !rsp_strobe)
      else $error("in-range query did not start a search");

endmodule

`default_nettype wire
